// File: rtl/core/ord_pkg.sv
package ord_pkg;

    // Framing phase of the tracker
    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    // Role tag carried with every byte
    typedef enum logic [2:0] {
        ROLE_PAD     = 3'd0,
        ROLE_TYPE    = 3'd1,
        ROLE_LEN_LO  = 3'd2,
        ROLE_LEN_HI  = 3'd3,
        ROLE_PAYLOAD = 3'd4,
        ROLE_CHECK   = 3'd5
    } role_t;

    localparam logic [7:0] PAD_BYTE = 8'h00;

    // One result transaction
    typedef struct packed {
        logic [7:0]  byte_value;
        role_t       role;
        logic [7:0]  record_kind;
        logic [15:0] payload_offset;
        logic        checksum_bad;
        logic        length_bad;
        logic        record_end;
    } result_t;

endpackage

// File: rtl/core/ord_tracker.sv
module ord_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       in_byte,
    input  logic             pad_skip_enable,
    output ord_pkg::result_t result
);
    import ord_pkg::*;

    phase_t      phase_reg,        phase_next;
    logic [15:0] bytes_left_reg,   bytes_left_next;
    logic [7:0]  running_sum_reg,  running_sum_next;
    logic [7:0]  current_kind_reg, current_kind_next;
    logic [7:0]  length_low_reg,   length_low_next;
    logic [15:0] offset_count_reg, offset_count_next;
    logic [15:0] len;
    logic [15:0] left_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TYPE;
            bytes_left_reg   <= '0;
            running_sum_reg  <= '0;
            current_kind_reg <= '0;
            length_low_reg   <= '0;
            offset_count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            running_sum_reg  <= running_sum_next;
            current_kind_reg <= current_kind_next;
            length_low_reg   <= length_low_next;
            offset_count_reg <= offset_count_next;
        end
    end

    assign len      = {in_byte, length_low_reg};
    assign left_dec = bytes_left_reg - 16'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        running_sum_next  = running_sum_reg;
        current_kind_next = current_kind_reg;
        length_low_next   = length_low_reg;
        offset_count_next = offset_count_reg;

        result.byte_value     = in_byte;
        result.role           = ROLE_TYPE;
        result.record_kind    = current_kind_reg;
        result.payload_offset = '0;
        result.checksum_bad   = 1'b0;
        result.length_bad     = 1'b0;
        result.record_end     = 1'b0;

        case (phase_reg)
            PH_LEN_LO:
            begin
                result.role      = ROLE_LEN_LO;
                length_low_next  = in_byte;
                running_sum_next = running_sum_reg + in_byte;
                phase_next       = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                result.role       = ROLE_LEN_HI;
                running_sum_next  = running_sum_reg + in_byte;
                offset_count_next = '0;
                if (len == 16'd0)
                begin
                    // zero length: flag it, take the next byte as checksum
                    result.length_bad = 1'b1;
                    bytes_left_next   = '0;
                    phase_next        = PH_CHECK;
                end
                else
                begin
                    bytes_left_next = len - 16'd1;
                    phase_next      = (len == 16'd1) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                result.role           = ROLE_PAYLOAD;
                result.payload_offset = offset_count_reg;
                offset_count_next     = offset_count_reg + 16'd1;
                running_sum_next      = running_sum_reg + in_byte;
                bytes_left_next       = left_dec;
                if (left_dec == 16'd0)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                result.role         = ROLE_CHECK;
                result.checksum_bad = ((8'd0 - running_sum_reg) != in_byte);
                result.record_end   = 1'b1;
                running_sum_next    = '0;
                phase_next          = PH_TYPE;
            end
            default:
            begin
                if (in_byte == PAD_BYTE && pad_skip_enable)
                begin
                    // padding: tag it as pad, state holds
                    result.role        = ROLE_PAD;
                    result.record_kind = '0;
                    phase_next         = PH_TYPE;
                end
                else
                begin
                    result.role        = ROLE_TYPE;
                    result.record_kind = in_byte;
                    current_kind_next  = in_byte;
                    running_sum_next   = in_byte;
                    offset_count_next  = '0;
                    bytes_left_next    = '0;
                    phase_next         = PH_LEN_LO;
                end
            end
        endcase
    end

endmodule

// File: rtl/core/ord_out_stage.sv
module ord_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ord_pkg::result_t result_in,
    input  logic             out_stall,
    output logic             ready,
    output logic             out_valid,
    output ord_pkg::result_t result_out
);
    import ord_pkg::*;

    logic    out_valid_reg;
    result_t result_reg;

    // free when empty or when the held transaction leaves this cycle
    assign ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready)
            out_valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
            result_reg <= result_in;
    end

    assign out_valid  = out_valid_reg;
    assign result_out = result_reg;

endmodule

// File: rtl/core/object_record_deframer_core.sv
// Datapath: a byte taken into the input register passes through the framing tracker into the
// result register once the result register can take it (input register, result register).
// Throughput: one byte per cycle unless the output stalls; the framing state updates in a
// single pass per byte. Under output stall the result and input registers each hold a byte.
// Reset (rst_n low, asynchronous): both stages empty, tracker expects a type byte with all
// counters and the running sum at zero, pad_skip_enable returns to 1.
module object_record_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        pad_skip_enable_wr,
    input  logic        pad_skip_enable,
    // byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_value,
    output logic [2:0]  role,
    output logic [7:0]  record_kind,
    output logic [15:0] payload_offset,
    output logic        checksum_bad,
    output logic        length_bad,
    output logic        record_end
);
    import ord_pkg::*;

    logic       pad_skip_enable_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_ready;
    logic       advance;
    result_t    step_result;
    result_t    out_result;

    // Configuration register: the user must write it only while the block is idle; not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_skip_enable_reg <= 1'b1;
        else if (pad_skip_enable_wr)
            pad_skip_enable_reg <= pad_skip_enable;
    end

    // Input register. A held byte moves to the result stage whenever that
    // stage can take it; the input side stalls only when the held byte
    // cannot move, so a new transaction enters every cycle while the output does not stall.
    assign advance  = in_valid_reg && out_ready;
    assign in_stall = in_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= data_byte;
    end

    // Framing tracker: classify the held byte and advance the record state
    // in the same cycle the byte moves to the result register.
    ord_tracker u_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .in_byte         (in_byte_reg),
        .pad_skip_enable (pad_skip_enable_reg),
        .result          (step_result)
    );

    // Result register: holds a finished transaction while the consumer stalls.
    ord_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (step_result),
        .out_stall  (out_stall),
        .ready      (out_ready),
        .out_valid  (out_valid),
        .result_out (out_result)
    );

    assign byte_value     = out_result.byte_value;
    assign role           = out_result.role;
    assign record_kind    = out_result.record_kind;
    assign payload_offset = out_result.payload_offset;
    assign checksum_bad   = out_result.checksum_bad;
    assign length_bad     = out_result.length_bad;
    assign record_end     = out_result.record_end;

    // The end-of-record mark only ever rides on a checksum byte.
    a_end_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_end |-> role == ROLE_CHECK)
        else $error("record_end on a non-checksum byte");

    // A checksum mismatch is reported only together with the record end.
    a_bad_sum_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && checksum_bad |-> record_end)
        else $error("checksum_bad without record_end");

    // Zero-length flag only on the length high byte.
    a_len_bad_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_bad |-> role == ROLE_LEN_HI)
        else $error("length_bad on wrong byte role");

    // A nonzero offset is only meaningful on payload bytes.
    a_offset_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_offset != 16'd0 |-> role == ROLE_PAYLOAD)
        else $error("payload_offset set outside payload");

    // Input stalls only while the result side is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while result stage free");

endmodule
